// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// widths, transaction types and helpers of the 3x3 inverse pipeline
// ----------------------------------------------------------------------------
package m3inv_pkg;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int N_ELEM  = 9;
   localparam int N_DIV   = 10;
   localparam int REC_IDX = 9;

   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int COF_W  = 2 * DATA_WIDTH + 1;
   localparam int CMAG_W = 2 * DATA_WIDTH;
   localparam int HI_W   = COF_W - DATA_WIDTH;
   localparam int PART_W = 2 * DATA_WIDTH + 1;
   localparam int SUM_W  = PART_W + 2;
   localparam int DET_W  = 3 * DATA_WIDTH + 1;
   localparam int MAG_W  = 3 * DATA_WIDTH;
   localparam int DEN_W  = MAG_W + 1;

   localparam int INV_SHIFT = 2 * FRAC_BITS + 1;
   localparam int REC_SHIFT = 4 * FRAC_BITS + 1;
   localparam int DET_SHIFT = 2 * FRAC_BITS;

   localparam int NUM_W =
      max_int(max_int(CMAG_W + INV_SHIFT, MAG_W), REC_SHIFT + 1) + 1;
   localparam int Q_W      = DATA_WIDTH;
   localparam int HI_REM_W = NUM_W - Q_W;
   localparam int CMP_W    = max_int(HI_REM_W, DEN_W);

   // divider: entry compare, one stage per quotient bit, saturation
   localparam int DIV_LAT = Q_W + 2;

   // cofactor k = a[i]*a[j] - a[p]*a[q], elements row major
   localparam logic [3:0] COF_IDX [0:N_ELEM-1][0:3] = '{
      '{4'd8, 4'd4, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd8, 4'd1}, '{4'd5, 4'd1, 4'd4, 4'd2},
      '{4'd6, 4'd5, 4'd8, 4'd3}, '{4'd8, 4'd0, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd5, 4'd0},
      '{4'd7, 4'd3, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd7, 4'd0}, '{4'd4, 4'd0, 4'd3, 4'd1}
   };

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] m00;
      logic signed [DATA_WIDTH-1:0] m01;
      logic signed [DATA_WIDTH-1:0] m02;
      logic signed [DATA_WIDTH-1:0] m10;
      logic signed [DATA_WIDTH-1:0] m11;
      logic signed [DATA_WIDTH-1:0] m12;
      logic signed [DATA_WIDTH-1:0] m20;
      logic signed [DATA_WIDTH-1:0] m21;
      logic signed [DATA_WIDTH-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] inv00;
      logic signed [DATA_WIDTH-1:0] inv01;
      logic signed [DATA_WIDTH-1:0] inv02;
      logic signed [DATA_WIDTH-1:0] inv10;
      logic signed [DATA_WIDTH-1:0] inv11;
      logic signed [DATA_WIDTH-1:0] inv12;
      logic signed [DATA_WIDTH-1:0] inv20;
      logic signed [DATA_WIDTH-1:0] inv21;
      logic signed [DATA_WIDTH-1:0] inv22;
      logic signed [DATA_WIDTH-1:0] determinant;
      logic signed [DATA_WIDTH-1:0] reciprocal_det;
      logic                         singular;
   } rsp_type;

   typedef struct packed {
      logic [N_ELEM-1:0][COF_W-1:0] cof;
      logic [DATA_WIDTH-1:0]        a0;
      logic [DATA_WIDTH-1:0]        a3;
      logic [DATA_WIDTH-1:0]        a6;
   } cof_type;

   typedef struct packed {
      logic [N_DIV-1:0][NUM_W-1:0] num;
      logic [N_DIV-1:0]            neg;
      logic [DEN_W-1:0]            den;
      logic [DATA_WIDTH-1:0]       det_out;
      logic                        singular;
   } div_in_type;

   // clamp a sign and magnitude to the signed output range
   function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic [MAG_W-1:0] mag,
                                                     input logic neg);
      logic [MAG_W-1:0]      limit;
      logic [DATA_WIDTH-1:0] res;
      limit = MAG_W'(1) << (DATA_WIDTH - 1);
      if (!neg) begin
         if (mag >= limit) res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         else res = mag[DATA_WIDTH-1:0];
      end else begin
         if (mag > limit) res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         else res = ~mag[DATA_WIDTH-1:0] + 1'b1;
      end
      return res;
   endfunction

endpackage

// File: src/m3inv_cofactor.sv
// ----------------------------------------------------------------------------
// m3inv_cofactor
// two stages: eighteen element products, then the nine exact cofactors
// ----------------------------------------------------------------------------
module m3inv_cofactor (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  m3inv_pkg::req_type in_data,
   output logic               out_valid,
   output m3inv_pkg::cof_type out_data
);
   import m3inv_pkg::*;

   logic signed [DATA_WIDTH-1:0] elem [N_ELEM];
   logic signed [PROD_W-1:0]     p_in [N_ELEM];
   logic signed [PROD_W-1:0]     q_in [N_ELEM];
   logic signed [PROD_W-1:0]     p_ff [N_ELEM];
   logic signed [PROD_W-1:0]     q_ff [N_ELEM];
   logic signed [COF_W-1:0]      cof_in [N_ELEM];
   logic signed [COF_W-1:0]      cof_ff [N_ELEM];
   logic [2:0][DATA_WIDTH-1:0]   col_a_ff;
   logic [2:0][DATA_WIDTH-1:0]   col_b_ff;
   logic                         va_ff;
   logic                         vb_ff;

   assign elem[0] = in_data.m00;
   assign elem[1] = in_data.m01;
   assign elem[2] = in_data.m02;
   assign elem[3] = in_data.m10;
   assign elem[4] = in_data.m11;
   assign elem[5] = in_data.m12;
   assign elem[6] = in_data.m20;
   assign elem[7] = in_data.m21;
   assign elem[8] = in_data.m22;

   for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
      assign p_in[k]   = elem[COF_IDX[k][0]] * elem[COF_IDX[k][1]];
      assign q_in[k]   = elem[COF_IDX[k][2]] * elem[COF_IDX[k][3]];
      assign cof_in[k] = p_ff[k] - q_ff[k];

      always_ff @(posedge clock) begin
         p_ff[k]   <= p_in[k];
         q_ff[k]   <= q_in[k];
         cof_ff[k] <= cof_in[k];
      end

      assign out_data.cof[k] = cof_ff[k];
   end

   always_ff @(posedge clock) begin
      col_a_ff <= {elem[6], elem[3], elem[0]};
      col_b_ff <= col_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   assign out_data.a0 = col_b_ff[0];
   assign out_data.a3 = col_b_ff[1];
   assign out_data.a6 = col_b_ff[2];
   assign out_valid   = vb_ff;

endmodule

// File: src/m3inv_det.sv
// ----------------------------------------------------------------------------
// m3inv_det
// determinant by expansion down column 0 from split partial products,
// then magnitudes and divider operands for the ten quotients
// ----------------------------------------------------------------------------
module m3inv_det (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  m3inv_pkg::cof_type    in_data,
   output logic                  out_valid,
   output m3inv_pkg::div_in_type out_data
);
   import m3inv_pkg::*;

   logic signed [DATA_WIDTH-1:0] col_a [3];
   logic signed [HI_W-1:0]       chi [3];
   logic signed [DATA_WIDTH:0]   clo [3];
   logic signed [PART_W-1:0]     ph_in [3];
   logic signed [PART_W-1:0]     pl_in [3];
   logic signed [PART_W-1:0]     ph_ff [3];
   logic signed [PART_W-1:0]     pl_ff [3];

   logic [N_ELEM-1:0][CMAG_W-1:0] cmag_in;
   logic [N_ELEM-1:0]             cneg_in;
   logic [N_ELEM-1:0][CMAG_W-1:0] cmag_c_ff, cmag_d_ff, cmag_e_ff, cmag_f_ff;
   logic [N_ELEM-1:0]             cneg_c_ff, cneg_d_ff, cneg_e_ff, cneg_f_ff;

   logic signed [SUM_W-1:0] hi_sum_in, lo_sum_in, hi_sum_ff, lo_sum_ff;
   logic signed [DET_W-1:0] hi_ext, lo_ext, det_in, det_ff;
   logic [DET_W-1:0]        det_abs;
   logic [MAG_W-1:0]        dmag_ff;
   logic                    dneg_ff, dzero_ff;
   logic [MAG_W:0]          rnd_sum;
   logic [MAG_W-1:0]        rnd_mag;
   div_in_type              out_in, out_ff;

   logic vc_ff, vd_ff, ve_ff, vf_ff, vg_ff;

   assign col_a[0] = in_data.a0;
   assign col_a[1] = in_data.a3;
   assign col_a[2] = in_data.a6;

   // stage c: a*C as a*C_hi*2^DW + a*C_lo, each about DW by DW
   for (genvar d = 0; d < 3; d++) begin : g_part
      assign chi[d]   = in_data.cof[d][COF_W-1:DATA_WIDTH];
      assign clo[d]   = {1'b0, in_data.cof[d][DATA_WIDTH-1:0]};
      assign ph_in[d] = col_a[d] * chi[d];
      assign pl_in[d] = col_a[d] * clo[d];
      always_ff @(posedge clock) begin
         ph_ff[d] <= ph_in[d];
         pl_ff[d] <= pl_in[d];
      end
   end

   for (genvar k = 0; k < N_ELEM; k++) begin : g_cmag
      logic [COF_W-1:0] cabs;
      assign cneg_in[k] = in_data.cof[k][COF_W-1];
      assign cabs       = cneg_in[k] ? (~in_data.cof[k] + 1'b1) : in_data.cof[k];
      assign cmag_in[k] = cabs[CMAG_W-1:0];
   end

   // stage d: column sums of the high and low partial products
   assign hi_sum_in = ph_ff[0] + ph_ff[1] + ph_ff[2];
   assign lo_sum_in = pl_ff[0] + pl_ff[1] + pl_ff[2];

   // stage e: recombine
   assign hi_ext = DET_W'(hi_sum_ff);
   assign lo_ext = DET_W'(lo_sum_ff);
   assign det_in = (hi_ext <<< DATA_WIDTH) + lo_ext;

   assign det_abs = det_ff[DET_W-1] ? (~det_ff + 1'b1) : det_ff;

   // stage g: operands of the dividers, rounded determinant
   assign rnd_sum = (MAG_W+1)'(dmag_ff) + ((MAG_W+1)'(1) << (DET_SHIFT - 1));
   assign rnd_mag = MAG_W'(rnd_sum >> DET_SHIFT);

   always_comb begin
      out_in = '0;
      for (int k = 0; k < N_ELEM; k++) begin
         out_in.num[k] = (NUM_W'(cmag_f_ff[k]) << INV_SHIFT) + NUM_W'(dmag_ff);
         out_in.neg[k] = cneg_f_ff[k] ^ dneg_ff;
      end
      out_in.num[REC_IDX] = (NUM_W'(1) << REC_SHIFT) + NUM_W'(dmag_ff);
      out_in.neg[REC_IDX] = dneg_ff;
      out_in.den          = {dmag_ff, 1'b0};
      out_in.det_out      = sat_mag(rnd_mag, dneg_ff);
      out_in.singular     = dzero_ff;
   end

   always_ff @(posedge clock) begin
      cmag_c_ff <= cmag_in;
      cneg_c_ff <= cneg_in;
      hi_sum_ff <= hi_sum_in;
      lo_sum_ff <= lo_sum_in;
      cmag_d_ff <= cmag_c_ff;
      cneg_d_ff <= cneg_c_ff;
      det_ff    <= det_in;
      cmag_e_ff <= cmag_d_ff;
      cneg_e_ff <= cneg_d_ff;
      dmag_ff   <= det_abs[MAG_W-1:0];
      dneg_ff   <= det_ff[DET_W-1];
      dzero_ff  <= (det_ff == '0);
      cmag_f_ff <= cmag_e_ff;
      cneg_f_ff <= cneg_e_ff;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else begin
         vc_ff <= in_valid;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   assign out_valid = vg_ff;
   assign out_data  = out_ff;

endmodule

// File: src/m3inv_divider.sv
// ----------------------------------------------------------------------------
// m3inv_divider
// pipelined restoring divider, one quotient bit per stage, with sign
// and saturation to the output format
// ----------------------------------------------------------------------------
module m3inv_divider (
   input  logic                                 clock,
   input  logic [m3inv_pkg::NUM_W-1:0]          num,
   input  logic [m3inv_pkg::DEN_W-1:0]          den,
   input  logic                                 neg,
   output logic [m3inv_pkg::DATA_WIDTH-1:0]     res
);
   import m3inv_pkg::*;

   logic [DEN_W-1:0] rem_ff  [0:Q_W];
   logic [DEN_W-1:0] den_ff  [0:Q_W];
   logic [Q_W-1:0]   low_ff  [0:Q_W];
   logic [Q_W-1:0]   quo_ff  [0:Q_W];
   logic             ovf_ff  [0:Q_W];
   logic             neg_ff  [0:Q_W];
   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;
   logic [DATA_WIDTH-1:0] res_ff;

   // quotient at or above 2^Q_W saturates whatever the sign
   assign hi_ext  = CMP_W'(num[NUM_W-1:Q_W]);
   assign den_ext = CMP_W'(den);

   always_ff @(posedge clock) begin
      rem_ff[0] <= hi_ext[DEN_W-1:0];
      den_ff[0] <= den;
      low_ff[0] <= num[Q_W-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= (hi_ext >= den_ext);
      neg_ff[0] <= neg;
   end

   for (genvar j = 1; j <= Q_W; j++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;
      logic [DEN_W-1:0] rem_in;

      assign trial  = {rem_ff[j-1], low_ff[j-1][Q_W-1]};
      assign diff   = trial - {1'b0, den_ff[j-1]};
      assign take   = !diff[DEN_W];
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_ff[j-1];
         low_ff[j] <= {low_ff[j-1][Q_W-2:0], 1'b0};
         quo_ff[j] <= {quo_ff[j-1][Q_W-2:0], take};
         ovf_ff[j] <= ovf_ff[j-1];
         neg_ff[j] <= neg_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= sat_mag(MAG_W'({ovf_ff[Q_W], quo_ff[Q_W]}), neg_ff[Q_W]);
   end

   assign res = res_ff;

endmodule

// File: src/matrix3x3_inverse_with_determinant_top.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_with_determinant_top
// 3x3 Q16.16 inverse by adjugate, with determinant and reciprocal
// ----------------------------------------------------------------------------
// One matrix is taken each cycle when start is high and busy is low; busy is
// high only during reset and the cycle after it. Each transaction gives its
// result on rsp_data with rsp_valid high for one cycle, in order, and the
// receiver cannot stall the pipeline. The result passes through the cofactor
// product stages, the determinant and operand set-up stages, the ten parallel
// restoring dividers (one quotient bit per stage) and one output register. A
// zero determinant gives singular high with zero inverse, determinant and
// reciprocal.
`include "assert_macros.svh"

module matrix3x3_inverse_with_determinant_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  m3inv_pkg::req_type req_data,
   output logic               rsp_valid,
   output m3inv_pkg::rsp_type rsp_data
);
   import m3inv_pkg::*;

   localparam int TOTAL_LAT = 2 + 5 + DIV_LAT + 1;

   logic       busy_ff;
   logic       accept;
   logic       cof_valid;
   cof_type    cof_data;
   logic       div_valid;
   div_in_type div_data;
   logic [DATA_WIDTH-1:0] quo [N_DIV];

   logic                  dl_valid_ff [DIV_LAT];
   logic [DATA_WIDTH-1:0] dl_det_ff   [DIV_LAT];
   logic                  dl_sing_ff  [DIV_LAT];

   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   m3inv_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (cof_valid),
      .out_data  (cof_data)
   );

   m3inv_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_data   (cof_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   for (genvar k = 0; k < N_DIV; k++) begin : g_div
      m3inv_divider u_divider (
         .clock (clock),
         .num   (div_data.num[k]),
         .den   (div_data.den),
         .neg   (div_data.neg[k]),
         .res   (quo[k])
      );
   end

   // side data waits alongside the dividers
   always_ff @(posedge clock) begin
      dl_det_ff[0]  <= div_data.det_out;
      dl_sing_ff[0] <= div_data.singular;
      for (int i = 1; i < DIV_LAT; i++) begin
         dl_det_ff[i]  <= dl_det_ff[i-1];
         dl_sing_ff[i] <= dl_sing_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) dl_valid_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dl_valid_ff[0] <= div_valid;
         for (int i = 1; i < DIV_LAT; i++) dl_valid_ff[i] <= dl_valid_ff[i-1];
         rsp_valid_ff <= dl_valid_ff[DIV_LAT-1];
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.singular = dl_sing_ff[DIV_LAT-1];
      if (!dl_sing_ff[DIV_LAT-1]) begin
         rsp_in.inv00          = quo[0];
         rsp_in.inv01          = quo[1];
         rsp_in.inv02          = quo[2];
         rsp_in.inv10          = quo[3];
         rsp_in.inv11          = quo[4];
         rsp_in.inv12          = quo[5];
         rsp_in.inv20          = quo[6];
         rsp_in.inv21          = quo[7];
         rsp_in.inv22          = quo[8];
         rsp_in.determinant    = dl_det_ff[DIV_LAT-1];
         rsp_in.reciprocal_det = quo[REC_IDX];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // fixed latency from accepted transaction to result
   `ASSERT_ALWAYS(a_latency, clock, reset, rsp_valid == $past(start && !busy, TOTAL_LAT), "result latency mismatch")
   // singular result carries zero determinant and reciprocal
   `ASSERT_IMPLY(a_singular_zero, clock, reset, rsp_valid && rsp_data.singular, rsp_data.determinant == '0 && rsp_data.reciprocal_det == '0, "singular result not zeroed")
   // reciprocal and rounded determinant agree in sign
   `ASSERT_IMPLY(a_recip_sign, clock, reset, rsp_valid && !rsp_data.singular && rsp_data.determinant != '0 && rsp_data.reciprocal_det != '0, rsp_data.reciprocal_det[DATA_WIDTH-1] == rsp_data.determinant[DATA_WIDTH-1], "reciprocal sign mismatch")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for the 3x3 adjugate inverse with determinant
// ----------------------------------------------------------------------------
// Matrices are sent with random gaps: first a short directed set, then random
// ones. An exact wide-integer predictor works out each expected result, and
// every strobed result is checked in order against it.
import m3inv_pkg::*;

class inverse_scoreboard;
   typedef logic signed [255:0] wide_type;

   rsp_type pending[$];
   int      errors = 0;

   // round to nearest, ties away from zero, then clamp to 32 bits
   function automatic logic [DATA_WIDTH-1:0] round_div(wide_type n, wide_type d);
      wide_type mn, md, q;
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = (2 * mn + md) / (2 * md);
      if ((n < 0) != (d < 0)) q = -q;
      if (q > wide_type'(32'h7fffffff)) return 32'h7fffffff;
      if (q < -(wide_type'(1) <<< 31)) return 32'h80000000;
      return q[DATA_WIDTH-1:0];
   endfunction

   function void note_matrix(req_type m);
      logic [3:0] pick [0:8][0:3];
      wide_type a [0:8];
      wide_type cof [0:8];
      wide_type det;
      rsp_type  r;
      logic [DATA_WIDTH-1:0] inv [0:8];
      pick = '{'{8, 4, 7, 5}, '{7, 2, 8, 1}, '{5, 1, 4, 2},
               '{6, 5, 8, 3}, '{8, 0, 6, 2}, '{3, 2, 5, 0},
               '{7, 3, 6, 4}, '{6, 1, 7, 0}, '{4, 0, 3, 1}};
      a = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
      foreach (cof[k])
         cof[k] = a[pick[k][0]] * a[pick[k][1]] - a[pick[k][2]] * a[pick[k][3]];
      det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
      end else begin
         foreach (inv[k]) inv[k] = round_div(cof[k] <<< (2 * FRAC_BITS), det);
         {r.inv00, r.inv01, r.inv02, r.inv10, r.inv11, r.inv12,
          r.inv20, r.inv21, r.inv22} = {inv[0], inv[1], inv[2], inv[3], inv[4],
                                        inv[5], inv[6], inv[7], inv[8]};
         r.determinant    = round_div(det, wide_type'(1) <<< (2 * FRAC_BITS));
         r.reciprocal_det = round_div(wide_type'(1) <<< (4 * FRAC_BITS), det);
      end
      pending.push_back(r);
   endfunction

   function void check_result(rsp_type got);
      string   names [0:11];
      rsp_type want;
      logic [DATA_WIDTH-1:0] ev [0:11];
      logic [DATA_WIDTH-1:0] av [0:11];
      names = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12", "inv20",
                "inv21", "inv22", "determinant", "reciprocal_det", "singular"};
      if (pending.size() == 0) begin
         $error("unexpected result transaction");
         errors++;
         return;
      end
      want = pending.pop_front();
      ev = '{want.inv00, want.inv01, want.inv02, want.inv10, want.inv11, want.inv12,
             want.inv20, want.inv21, want.inv22, want.determinant,
             want.reciprocal_det, DATA_WIDTH'(want.singular)};
      av = '{got.inv00, got.inv01, got.inv02, got.inv10, got.inv11, got.inv12,
             got.inv20, got.inv21, got.inv22, got.determinant,
             got.reciprocal_det, DATA_WIDTH'(got.singular)};
      foreach (ev[k])
         if (ev[k] !== av[k]) begin
            $error("%s: expected %h, actual %h", names[k], ev[k], av[k]);
            errors++;
         end
   endfunction
endclass

module tb;
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   inverse_scoreboard inv_board = new();
   int unsigned cycles = 0;

   matrix3x3_inverse_with_determinant_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) inv_board.check_result(rsp_data);
   end

   // send one matrix after a random gap; start stays high across back-to-back items
   task automatic send_matrix(req_type m);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= m;
      do @(posedge clock); while (busy);
      inv_board.note_matrix(m);
   endtask

   function automatic logic [31:0] pick_elem(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         3: return 32'($signed($urandom_range(0, 64)) - 32);
         default: return 32'($signed($urandom_range(0, 1024)) - 512) <<< 8;
      endcase
   endfunction

   function automatic req_type random_matrix();
      logic [31:0] e [0:8];
      int mode, kind, r;
      kind = $urandom_range(0, 9);
      mode = $urandom_range(0, 4);
      foreach (e[k]) e[k] = pick_elem(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4)
                                                                  : mode);
      if (kind == 0) begin
         // duplicate one row onto another for a singular matrix
         r = $urandom_range(0, 2);
         for (int c = 0; c < 3; c++) e[((r + 1) % 3) * 3 + c] = e[r * 3 + c];
      end else if (kind == 1) begin
         r = $urandom_range(0, 2);
         for (int c = 0; c < 3; c++) e[c * 3 + r] = '0;
      end else if (kind == 2) begin
         // diagonal matrix, small determinants push the reciprocal to saturation
         foreach (e[k]) if (k % 4 != 0) e[k] = '0;
      end
      return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
   endfunction

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7fffffff;
   localparam logic [31:0] MINV = 32'h80000000;

   initial begin
      req_type dir [$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      dir.push_back({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
      dir.push_back('0);
      dir.push_back({9{MAXV}});
      dir.push_back({9{MINV}});
      dir.push_back({MAXV, 32'd0, 32'd0, 32'd0, MAXV, 32'd0, 32'd0, 32'd0, MAXV});
      dir.push_back({MINV, 32'd0, 32'd0, 32'd0, MINV, 32'd0, 32'd0, 32'd0, MINV});
      dir.push_back({MINV, MAXV, 32'd0, MAXV, MINV, MAXV, 32'd0, MAXV, MINV});
      dir.push_back({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
      dir.push_back({32'd2, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
      dir.push_back({-ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
      dir.push_back({32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE});
      dir.push_back({ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                     7 * ONE, 8 * ONE, 9 * ONE});
      dir.push_back({2 * ONE, 32'd0, 32'd0, 32'd0, 2 * ONE, 32'd0, 32'd0, 32'd0,
                     2 * ONE});
      dir.push_back({3 * ONE, 32'd0, 32'd0, 32'd0, 3 * ONE, 32'd0, 32'd0, 32'd0,
                     3 * ONE});
      dir.push_back({32'hffffffff, 32'd5, 32'd7, 32'd3, 32'hfffffffe, 32'd1,
                     32'd4, 32'd9, 32'd2});
      dir.push_back({ONE, ONE, 32'd0, 32'd0, ONE, ONE, ONE, 32'd0, ONE});
      foreach (dir[i]) send_matrix(dir[i]);
      for (int i = 0; i < 2000; i++) send_matrix(random_matrix());
      start <= 1'b0;
      while (inv_board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (inv_board.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+src
src/m3inv_pkg.sv
src/m3inv_cofactor.sv
src/m3inv_det.sv
src/m3inv_divider.sv
src/matrix3x3_inverse_with_determinant_top.sv
tb/sv/tb.sv
